/* sv/pwbe_pkg.sv */
// Package for the pulse-width bitstream encoder.
// Holds command codes, register indexes and the queue item types.
// No dependencies; used by pwbe_cfg, pwbe_front, pwbe_back and the top level.
`default_nettype none

package pwbe_pkg;

  // Command codes of an input item
  localparam logic CmdTick = 1'b0;
  localparam logic CmdLoad = 1'b1;

  // Width of the byte field on the input channel
  localparam int unsigned ByteW = 8;

  // Timing register indexes
  localparam int unsigned NumRegs     = 4;
  localparam int unsigned RegIdxW     = 2;
  localparam logic [RegIdxW-1:0] RegZeroHigh = 2'd0;
  localparam logic [RegIdxW-1:0] RegZeroLow  = 2'd1;
  localparam logic [RegIdxW-1:0] RegOneHigh  = 2'd2;
  localparam logic [RegIdxW-1:0] RegOneLow   = 2'd3;

  // APB port sizes
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  // Reset timings, in ticks
  localparam int unsigned ZeroHighReset = 48;
  localparam int unsigned ZeroLowReset  = 102;
  localparam int unsigned OneHighReset  = 96;
  localparam int unsigned OneLowReset   = 54;

  // Classified item held in the queue between front and back
  typedef struct packed {
    logic             is_load;
    logic [ByteW-1:0] data_byte;
    logic             final_byte;
  } cmd_item_t;

  // Result item
  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic accepted;
    logic stream_done;
  } result_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

/* sv/pwbe_if.sv */
// Channel interfaces of the pulse-width bitstream encoder.
// Input channel carries commands, output channel carries results.
// Depends on nothing but the item field widths.
`default_nettype none

interface pwbe_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output cmd, output data_byte, output final_byte,
                  input ready);
  modport sink   (input valid, input cmd, input data_byte, input final_byte,
                  output ready);
endinterface

interface pwbe_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic accepted;
  logic stream_done;

  modport source (output valid, output pin_level, output busy_res,
                  output accepted, output stream_done, input ready);
  modport sink   (input valid, input pin_level, input busy_res,
                  input accepted, input stream_done, output ready);
endinterface

`default_nettype wire

/* sv/pwbe_fifo.sv */
// Two-entry queue with registered storage.
// Generic width; used between front and back and on the result side.
// No package dependencies.
`default_nettype none

module pwbe_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* sv/pwbe_cfg.sv */
// APB timing register file of the pulse-width bitstream encoder.
// Four timing registers, written and read over APB.
// Depends on pwbe_pkg.
`default_nettype none

module pwbe_cfg #(
  parameter int unsigned TimeWidth = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pwbe_pkg::PaddrW-1:0]         paddr,
  input  wire logic [pwbe_pkg::PdataW-1:0]         pwdata,
  output logic      [pwbe_pkg::PdataW-1:0]         prdata,
  output logic                                     pready,
  output logic      [pwbe_pkg::NumRegs-1:0][TimeWidth-1:0] timing_o
);

  logic [pwbe_pkg::NumRegs-1:0][TimeWidth-1:0] timing_q;
  logic [pwbe_pkg::RegIdxW-1:0]                idx;
  logic                                        wr_en;

  assign pready   = 1'b1;
  assign idx      = paddr[pwbe_pkg::RegIdxW+1:2];
  assign wr_en    = psel && penable && pwrite;
  assign timing_o = timing_q;

  // Register writes; value keeps the low TimeWidth bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q[pwbe_pkg::RegZeroHigh] <= TimeWidth'(pwbe_pkg::ZeroHighReset);
      timing_q[pwbe_pkg::RegZeroLow]  <= TimeWidth'(pwbe_pkg::ZeroLowReset);
      timing_q[pwbe_pkg::RegOneHigh]  <= TimeWidth'(pwbe_pkg::OneHighReset);
      timing_q[pwbe_pkg::RegOneLow]   <= TimeWidth'(pwbe_pkg::OneLowReset);
    end else if (wr_en) begin
      timing_q[idx] <= pwdata[TimeWidth-1:0];
    end
  end

  // Read back, zero-extended
  assign prdata = pwbe_pkg::PdataW'(timing_q[idx]);

endmodule

`default_nettype wire

/* sv/pwbe_front.sv */
// Front part: accepts input items, classifies them, queues them.
// Uses pwbe_fifo as the two-entry queue toward the back part.
// Depends on pwbe_pkg and pwbe_if.
`default_nettype none

module pwbe_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  pwbe_in_if.sink              in_i,
  input  wire logic            pop_i,
  output pwbe_pkg::queue_head_t head_o
);

  pwbe_pkg::cmd_item_t wr_item;
  pwbe_pkg::cmd_item_t rd_item;
  logic                full, empty;

  // Classify the command
  always_comb begin
    wr_item.is_load    = (in_i.cmd == pwbe_pkg::CmdLoad);
    wr_item.data_byte  = in_i.data_byte;
    wr_item.final_byte = in_i.final_byte;
  end

  assign in_i.ready = !full;

  pwbe_fifo #(
    .Width($bits(pwbe_pkg::cmd_item_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_i.valid),
    .wdata_i (wr_item),
    .pop_i   (pop_i),
    .rdata_o (rd_item),
    .full_o  (full),
    .empty_o (empty)
  );

  assign head_o.valid = !empty;
  assign head_o.item  = rd_item;

endmodule

`default_nettype wire

/* sv/pwbe_back.sv */
// Back part: bit encoder state and the result queue.
// Takes one queued item a cycle while the result queue has room, and writes its result to a two-entry queue.
// Depends on pwbe_pkg, pwbe_if and pwbe_fifo.
`default_nettype none

module pwbe_back #(
  parameter int unsigned BitsPerByte = 8,
  parameter int unsigned TimeWidth   = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic [pwbe_pkg::NumRegs-1:0][TimeWidth-1:0] timing_i,
  input  pwbe_pkg::queue_head_t                           head_i,
  output logic                                            pop_o,
  pwbe_out_if.source                                      out_o
);

  localparam int unsigned CntW = $clog2(BitsPerByte + 1);
  localparam int unsigned ExtW = (BitsPerByte > pwbe_pkg::ByteW) ? BitsPerByte
                                                                  : pwbe_pkg::ByteW;

  logic [BitsPerByte-1:0] shift_q, shift_d;
  logic [CntW-1:0]        bits_left_q, bits_left_d;
  logic [TimeWidth:0]     phase_q, phase_d;
  logic                   sending_q, sending_d;
  logic                   last_q, last_d;

  logic                   out_full, out_empty;
  pwbe_pkg::result_t      res, res_out;
  logic [ExtW-1:0]        byte_ext;
  logic                   cur_bit;
  logic [TimeWidth-1:0]   hi, lo;
  logic [TimeWidth:0]     total, phase_inc;

  // Take an item whenever the result queue has room
  assign pop_o = head_i.valid && !out_full;

  assign byte_ext  = ExtW'(head_i.item.data_byte);
  assign cur_bit   = shift_q[BitsPerByte-1];
  assign hi        = cur_bit ? timing_i[pwbe_pkg::RegOneHigh]
                             : timing_i[pwbe_pkg::RegZeroHigh];
  assign lo        = cur_bit ? timing_i[pwbe_pkg::RegOneLow]
                             : timing_i[pwbe_pkg::RegZeroLow];
  assign total     = {1'b0, hi} + {1'b0, lo};
  assign phase_inc = phase_q + 1'b1;

  // Encoder step for the item at the queue head
  always_comb begin
    shift_d     = shift_q;
    bits_left_d = bits_left_q;
    phase_d     = phase_q;
    sending_d   = sending_q;
    last_d      = last_q;
    res         = '0;
    if (head_i.item.is_load) begin
      if (!sending_q) begin
        shift_d      = byte_ext[BitsPerByte-1:0];
        bits_left_d  = CntW'(BitsPerByte);
        phase_d      = '0;
        sending_d    = 1'b1;
        last_d       = head_i.item.final_byte;
        res.accepted = 1'b1;
      end
      res.busy_res = 1'b1;
    end else if (sending_q) begin
      res.busy_res  = 1'b1;
      res.pin_level = (phase_q < {1'b0, hi});
      phase_d       = phase_inc;
      // Bit ends: shift out and count down
      if (phase_inc >= total) begin
        phase_d     = '0;
        shift_d     = shift_q << 1;
        bits_left_d = bits_left_q - 1'b1;
        if (bits_left_q == CntW'(1)) begin
          sending_d       = 1'b0;
          res.stream_done = last_q;
          last_d          = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      bits_left_q <= '0;
      phase_q     <= '0;
      sending_q   <= 1'b0;
      last_q      <= 1'b0;
    end else if (pop_o) begin
      shift_q     <= shift_d;
      bits_left_q <= bits_left_d;
      phase_q     <= phase_d;
      sending_q   <= sending_d;
      last_q      <= last_d;
    end
  end

  // Result queue decouples the output handshake
  pwbe_fifo #(
    .Width($bits(pwbe_pkg::result_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pop_o),
    .wdata_i (res),
    .pop_i   (out_o.ready),
    .rdata_o (res_out),
    .full_o  (out_full),
    .empty_o (out_empty)
  );

  assign out_o.valid       = !out_empty;
  assign out_o.pin_level   = res_out.pin_level;
  assign out_o.busy_res    = res_out.busy_res;
  assign out_o.accepted    = res_out.accepted;
  assign out_o.stream_done = res_out.stream_done;

endmodule

`default_nettype wire

/* sv/pulse_width_bitstream_encoder_top.sv */
// Top level of the pulse-width bitstream encoder.
// Ties together pwbe_cfg, pwbe_front and pwbe_back; depends on pwbe_pkg, pwbe_if.
//
//   channel   dir   handshake        payload
//   in_i      in    valid/ready      cmd, data_byte, final_byte
//   out_o     out   valid/ready      pin_level, busy_res, accepted, stream_done
//   apb       in    psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One item per cycle sustained while out_o takes results; an item's result reaches
// out_o through the input queue, then the result queue register.
// Reset clears the encoder state and loads the default timings.
// A full result queue stalls the back part; the front keeps accepting until
// its two-entry queue fills.
`default_nettype none

module pulse_width_bitstream_encoder_top #(
  parameter int unsigned BITS_PER_BYTE = 8,
  parameter int unsigned TIME_WIDTH    = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  pwbe_in_if.sink                           in_i,
  pwbe_out_if.source                        out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pwbe_pkg::PaddrW-1:0]  paddr,
  input  wire logic [pwbe_pkg::PdataW-1:0]  pwdata,
  output logic      [pwbe_pkg::PdataW-1:0]  prdata,
  output logic                              pready
);

  logic [pwbe_pkg::NumRegs-1:0][TIME_WIDTH-1:0] timing;
  pwbe_pkg::queue_head_t                        head;
  logic                                         pop;

  pwbe_cfg #(
    .TimeWidth(TIME_WIDTH)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .timing_o (timing)
  );

  pwbe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  pwbe_back #(
    .BitsPerByte(BITS_PER_BYTE),
    .TimeWidth  (TIME_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .timing_i (timing),
    .head_i   (head),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire
